// ----- hdl/lpg_pkg.sv -----
// shared types and constants for the line pixel generator
package lpg_pkg;

    localparam int unsigned COORD_W = 12;
    localparam int unsigned ERR_W   = 13;
    localparam int unsigned ADDR_W  = 16;
    localparam int unsigned COLOR_W = 8;

    // command codes
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic        [COORD_W-1:0] t_delta;
    typedef logic        [ERR_W-1:0]   t_err;
    typedef logic signed [1:0]         t_dir;

    // one rasterized pixel on its way to the address stage
    typedef struct packed {
        logic   pixel_valid;
        t_coord x;
        t_coord y;
        logic   last;
    } t_pixel;

endpackage

// ----- hdl/lpg_stepper.sv -----
// bresenham state and first pipeline register
module lpg_stepper (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic             i_command,
    input  lpg_pkg::t_coord  i_start_x,
    input  lpg_pkg::t_coord  i_start_y,
    input  lpg_pkg::t_coord  i_end_x,
    input  lpg_pkg::t_coord  i_end_y,
    input  logic             i_drain,
    output logic             o_vld,
    output lpg_pkg::t_pixel  o_pix
);
    import lpg_pkg::*;

    t_coord r_cur_x, n_cur_x;
    t_coord r_cur_y, n_cur_y;
    t_err   r_err, n_err;
    t_delta r_abs_dx, n_abs_dx;
    t_delta r_abs_dy, n_abs_dy;
    t_dir   r_step_x, n_step_x;
    t_dir   r_step_y, n_step_y;
    logic   r_x_major, n_x_major;
    t_delta r_steps_left, n_steps_left;
    logic   r_active, n_active;
    logic   r_vld, n_vld;
    t_pixel r_pix, n_pix;

    logic signed [COORD_W:0] dx, dy;
    t_delta major;
    t_delta minor_d;
    t_delta major_d;
    t_err   err_sum;
    logic   minor_move;
    t_delta steps_dec;

    always_comb begin
        dx = {i_end_x[COORD_W-1], i_end_x} - {i_start_x[COORD_W-1], i_start_x};
        dy = {i_end_y[COORD_W-1], i_end_y} - {i_start_y[COORD_W-1], i_start_y};
        n_abs_dx  = dx[COORD_W] ? COORD_W'(-dx) : COORD_W'(dx);
        n_abs_dy  = dy[COORD_W] ? COORD_W'(-dy) : COORD_W'(dy);
        n_step_x  = dx[COORD_W] ? -2'sd1 : ((dx != '0) ? 2'sd1 : 2'sd0);
        n_step_y  = dy[COORD_W] ? -2'sd1 : ((dy != '0) ? 2'sd1 : 2'sd0);
        n_x_major = n_abs_dx >= n_abs_dy;
        major     = n_x_major ? n_abs_dx : n_abs_dy;

        // step path: error term on the registered state
        major_d    = r_x_major ? r_abs_dx : r_abs_dy;
        minor_d    = r_x_major ? r_abs_dy : r_abs_dx;
        err_sum    = r_err + {1'b0, minor_d};
        minor_move = err_sum >= {1'b0, major_d};
        steps_dec  = r_steps_left - 1'b1;

        n_cur_x      = r_cur_x;
        n_cur_y      = r_cur_y;
        n_err        = r_err;
        n_steps_left = r_steps_left;
        n_active     = r_active;
        n_pix        = r_pix;

        if (i_accept) begin
            if (i_command == CMD_START) begin
                n_cur_x      = i_start_x;
                n_cur_y      = i_start_y;
                n_err        = {1'b0, major} >> 1;
                n_steps_left = major;
                n_active     = major != '0;
                n_pix        = '{pixel_valid: 1'b1, x: i_start_x, y: i_start_y,
                                 last: major == '0};
            end else if (r_active) begin
                n_err = minor_move ? (err_sum - {1'b0, major_d}) : err_sum;
                if (r_x_major) begin
                    n_cur_x = r_cur_x + {{(COORD_W-2){r_step_x[1]}}, r_step_x};
                    if (minor_move) begin
                        n_cur_y = r_cur_y + {{(COORD_W-2){r_step_y[1]}}, r_step_y};
                    end
                end else begin
                    n_cur_y = r_cur_y + {{(COORD_W-2){r_step_y[1]}}, r_step_y};
                    if (minor_move) begin
                        n_cur_x = r_cur_x + {{(COORD_W-2){r_step_x[1]}}, r_step_x};
                    end
                end
                n_steps_left = steps_dec;
                n_active     = steps_dec != '0;
                n_pix        = '{pixel_valid: 1'b1, x: n_cur_x, y: n_cur_y,
                                 last: steps_dec == '0};
            end else begin
                // step with no line running
                n_pix = '{pixel_valid: 1'b0, x: '0, y: '0, last: 1'b0};
            end
        end

        if (i_accept) begin
            n_vld = 1'b1;
        end else if (i_drain) begin
            n_vld = 1'b0;
        end else begin
            n_vld = r_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x      <= '0;
            r_cur_y      <= '0;
            r_err        <= '0;
            r_abs_dx     <= '0;
            r_abs_dy     <= '0;
            r_step_x     <= '0;
            r_step_y     <= '0;
            r_x_major    <= 1'b0;
            r_steps_left <= '0;
            r_active     <= 1'b0;
            r_vld        <= 1'b0;
        end else begin
            r_cur_x      <= n_cur_x;
            r_cur_y      <= n_cur_y;
            r_err        <= n_err;
            r_steps_left <= n_steps_left;
            r_active     <= n_active;
            r_vld        <= n_vld;
            if (i_accept && (i_command == CMD_START)) begin
                r_abs_dx  <= n_abs_dx;
                r_abs_dy  <= n_abs_dy;
                r_step_x  <= n_step_x;
                r_step_y  <= n_step_y;
                r_x_major <= n_x_major;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pix <= n_pix;
    end

    assign o_vld = r_vld;
    assign o_pix = r_pix;

endmodule

// ----- hdl/lpg_classify.sv -----
// screen bounds check, frame address and output register
module lpg_classify #(
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 200
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  logic                          i_out_ready,
    input  lpg_pkg::t_pixel               i_pix,
    input  logic [lpg_pkg::COLOR_W-1:0]   i_color,
    output logic                          o_vld,
    output logic                          o_pixel_valid,
    output lpg_pkg::t_coord               o_pixel_x,
    output lpg_pkg::t_coord               o_pixel_y,
    output logic [lpg_pkg::ADDR_W-1:0]    o_frame_address,
    output logic [lpg_pkg::COLOR_W-1:0]   o_pixel_color,
    output logic                          o_visible,
    output logic                          o_last
);
    import lpg_pkg::*;

    localparam int unsigned MAG_W = COORD_W - 1;
    localparam logic [MAG_W-1:0] C_W = MAG_W'(SCREEN_WIDTH);
    localparam logic [MAG_W-1:0] C_H = MAG_W'(SCREEN_HEIGHT);

    logic                  r_vld, n_vld;
    logic                  r_pixel_valid;
    t_coord                r_x, r_y;
    logic [ADDR_W-1:0]     r_addr;
    logic [COLOR_W-1:0]    r_color;
    logic                  r_visible;
    logic                  r_last;

    logic                  vis;
    logic [2*MAG_W-1:0]    row_base;
    logic [2*MAG_W:0]      lin_addr;

    always_comb begin
        vis = i_pix.pixel_valid
              && !i_pix.x[COORD_W-1] && (i_pix.x[MAG_W-1:0] < C_W)
              && !i_pix.y[COORD_W-1] && (i_pix.y[MAG_W-1:0] < C_H);
        row_base = i_pix.y[MAG_W-1:0] * C_W;
        lin_addr = {1'b0, row_base} + (2*MAG_W+1)'(i_pix.x[MAG_W-1:0]);

        if (i_load) begin
            n_vld = 1'b1;
        end else if (i_out_ready) begin
            n_vld = 1'b0;
        end else begin
            n_vld = r_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_pixel_valid <= i_pix.pixel_valid;
            r_x           <= i_pix.x;
            r_y           <= i_pix.y;
            r_last        <= i_pix.last;
            r_visible     <= vis;
            r_addr        <= vis ? lin_addr[ADDR_W-1:0] : '0;
            r_color       <= i_pix.pixel_valid ? i_color : '0;
        end
    end

    assign o_vld           = r_vld;
    assign o_pixel_valid   = r_pixel_valid;
    assign o_pixel_x       = r_x;
    assign o_pixel_y       = r_y;
    assign o_frame_address = r_addr;
    assign o_pixel_color   = r_color;
    assign o_visible       = r_visible;
    assign o_last          = r_last;

endmodule

// ----- hdl/line_pixel_generator_core.sv -----
// top level of the bresenham line pixel generator
//
// usage
//   input channel (i_in_valid / o_in_stall): a transfer carries one command.
//   command start takes both endpoints and yields the first pixel; command
//   step yields the next pixel of the running line, or a result with
//   pixel_valid low when no line is running. every command yields one result.
//   output channel (o_out_valid / i_out_stall): one transfer per result, with
//   coordinates, frame address (zero when off screen), color, visible, last.
//   config channel (i_cfg_valid / o_cfg_ready): writes the draw color; ready
//   is always high, write only while the block is idle.
// timing
//   a result passes through the stepper register and then the address /
//   output register after its command transfer. one command per cycle is
//   sustained while the receiver does not stall; the multiply of the frame
//   address sits in the second stage.
// reset and stall
//   synchronous active-low reset idles the line, clears the draw color and
//   empties both pipeline registers. while the receiver stalls, the output
//   register holds; the stepper register still takes one more command, and
//   o_in_stall rises only when both registers are full.
module line_pixel_generator_core #(
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 200
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // command channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_command,
    input  lpg_pkg::t_coord               i_start_x,
    input  lpg_pkg::t_coord               i_start_y,
    input  lpg_pkg::t_coord               i_end_x,
    input  lpg_pkg::t_coord               i_end_y,
    // config channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [lpg_pkg::COLOR_W-1:0]   i_cfg_data,
    // pixel channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_pixel_valid,
    output lpg_pkg::t_coord               o_pixel_x,
    output lpg_pkg::t_coord               o_pixel_y,
    output logic [lpg_pkg::ADDR_W-1:0]    o_frame_address,
    output logic [lpg_pkg::COLOR_W-1:0]   o_pixel_color,
    output logic                          o_visible,
    output logic                          o_last
);
    import lpg_pkg::*;

    logic [COLOR_W-1:0] r_draw_color;

    logic   s1_vld;
    t_pixel s1_pix;
    logic   out_vld;
    logic   out_ready;   // output register free or emptying this cycle
    logic   s1_free;     // stepper register can take a command
    logic   drain;       // stepper register moves into the output register
    logic   accept;      // command transfer

    // pipeline control, the output stall reaches o_in_stall combinationally
    assign out_ready = !out_vld || !i_out_stall;
    assign drain     = s1_vld && out_ready;
    assign s1_free   = !s1_vld || out_ready;
    assign accept    = i_in_valid && s1_free;

    assign o_in_stall  = !s1_free;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = out_vld;

    // draw color register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_draw_color <= '0;
        end else if (i_cfg_valid) begin
            r_draw_color <= i_cfg_data;
        end
    end

    // bresenham stepping and the first pipeline register
    lpg_stepper u_stepper (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_command (i_command),
        .i_start_x (i_start_x),
        .i_start_y (i_start_y),
        .i_end_x   (i_end_x),
        .i_end_y   (i_end_y),
        .i_drain   (drain),
        .o_vld     (s1_vld),
        .o_pix     (s1_pix)
    );

    // bounds check, frame address and the result register
    lpg_classify #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_classify (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (drain),
        .i_out_ready     (out_ready),
        .i_pix           (s1_pix),
        .i_color         (r_draw_color),
        .o_vld           (out_vld),
        .o_pixel_valid   (o_pixel_valid),
        .o_pixel_x       (o_pixel_x),
        .o_pixel_y       (o_pixel_y),
        .o_frame_address (o_frame_address),
        .o_pixel_color   (o_pixel_color),
        .o_visible       (o_visible),
        .o_last          (o_last)
    );

endmodule
